>>> design/wmrcd_pkg.sv
package wmrcd_pkg;

	// Block sizing
	localparam int NUM_JOINTS   = 8;
	localparam int WINDOW_DEPTH = 8;

	// Derived widths
	localparam int MAG_W     = 31;
	localparam int ENTRIES   = NUM_JOINTS * WINDOW_DEPTH;
	localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PTR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int JSEL_W    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	// Input word
	typedef struct packed {
		logic [2:0]         joint_index;
		logic signed [31:0] residual;
		logic               last_joint;
	} in_t;

	// Result word
	typedef struct packed {
		logic       joint_exceeds;
		logic [3:0] collision_joint;
		logic       step_done;
	} out_t;

endpackage

>>> design/wmrcd_ram.sv
module wmrcd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/window_max_residual_collision_detect.sv
// Per-joint sliding-window collision detector. Each input word carries one
// signed Q16.16 residual for one joint; its magnitude (most negative value
// saturates) is compared against the largest of that joint's last
// WINDOW_DEPTH magnitudes plus the margin register, and the word that ends a
// time step reports the highest exceeding joint, 1-based, or 0. A word goes
// through the accept cycle, which also pushes the joint's previous magnitude
// into the window, one read of the window RAM per entry through its single
// read port, a drain state that folds in the last read, the margin compare
// and the result register load, which waits out a stalled result. in_stall
// is high while a word is in flight. The window RAM is cleared through
// per-entry valid bits, so no clearing pass follows reset. The user must
// write the margin with cfg_we only while idle; the block does not enforce it.
module window_max_residual_collision_detect import wmrcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_word,
	input  logic             cfg_we,
	input  logic [MAG_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [MAG_W-1:0]      margin_q;
	logic [MAG_W-1:0]      prev_mag_q [NUM_JOINTS];
	logic [PTR_W-1:0]      ptr_q [NUM_JOINTS];
	logic [ENTRIES-1:0]    valid_q;
	logic [3:0]            step_coll_q;

	// Item in flight
	logic [JSEL_W-1:0]     jsel_q;
	logic [2:0]            joint_q;
	logic [MAG_W-1:0]      mag_q;
	logic                  done_q;
	logic                  exceeds_q;
	logic [PTR_W-1:0]      rd_cnt_q;
	logic [MAG_W-1:0]      max_q;

	// Read pipeline
	logic                  rd_pend_s1;
	logic                  rd_valid_s1;

	logic                  in_accept;
	logic                  in_range;
	logic [JSEL_W-1:0]     jsel_in;
	logic [31:0]           neg_res;
	logic [MAG_W-1:0]      mag_in;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [MAG_W-1:0]      ram_rdata;
	logic [MAG_W-1:0]      rd_data;
	logic [MAG_W:0]        limit;
	logic                  out_free;
	logic [3:0]            joint_p1;
	logic [3:0]            step_coll_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_range  = (int'(in_word.joint_index) < NUM_JOINTS);
	assign jsel_in   = JSEL_W'(in_word.joint_index);

	// Magnitude with saturation of the most negative residual
	assign neg_res = ~in_word.residual + 32'd1;
	always_comb begin
		if (in_word.residual == 32'sh8000_0000) begin
			mag_in = '1;
		end else if (in_word.residual[31]) begin
			mag_in = neg_res[MAG_W-1:0];
		end else begin
			mag_in = in_word.residual[MAG_W-1:0];
		end
	end

	// Push previous magnitude into the window on accept
	assign ram_we    = in_accept && in_range;
	assign ram_waddr = ADDR_W'(int'(jsel_in) * WINDOW_DEPTH + int'(ptr_q[jsel_in]));
	assign ram_raddr = ADDR_W'(int'(jsel_q) * WINDOW_DEPTH + int'(rd_cnt_q));

	wmrcd_ram #(
		.WIDTH(MAG_W),
		.DEPTH(ENTRIES)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(prev_mag_q[jsel_in]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Entries never written read as zero
	assign rd_data = rd_valid_s1 ? ram_rdata : '0;

	// Threshold and step bookkeeping
	assign limit        = {1'b0, max_q} + {1'b0, margin_q};
	assign out_free     = !out_valid || !out_stall;
	assign joint_p1     = {1'b0, joint_q} + 4'd1;
	assign step_coll_nx = (exceeds_q && (joint_p1 > step_coll_q)) ? joint_p1 : step_coll_q;

	// Margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	// Sequencer, per-joint state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			step_coll_q <= '0;
			out_valid   <= 1'b0;
			out_word    <= '0;
			rd_pend_s1  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			jsel_q      <= '0;
			joint_q     <= '0;
			mag_q       <= '0;
			done_q      <= 1'b0;
			exceeds_q   <= 1'b0;
			rd_cnt_q    <= '0;
			max_q       <= '0;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				prev_mag_q[j] <= '0;
				ptr_q[j]      <= '0;
			end
		end else begin
			// Result taken; a new one loads in ST_FINISH instead
			if (out_valid && !out_stall && (state_q != ST_FINISH)) begin
				out_valid <= 1'b0;
			end

			rd_pend_s1  <= (state_q == ST_SCAN);
			rd_valid_s1 <= valid_q[ram_raddr];

			// Shared compare folds each window read into the running max
			if (rd_pend_s1 && (rd_data > max_q)) begin
				max_q <= rd_data;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						jsel_q    <= jsel_in;
						joint_q   <= in_word.joint_index;
						mag_q     <= mag_in;
						done_q    <= in_word.last_joint;
						exceeds_q <= 1'b0;
						rd_cnt_q  <= '0;
						max_q     <= '0;
						if (in_range) begin
							valid_q[ram_waddr] <= 1'b1;
							prev_mag_q[jsel_in] <= mag_in;
							if (ptr_q[jsel_in] == PTR_W'(WINDOW_DEPTH - 1)) begin
								ptr_q[jsel_in] <= '0;
							end else begin
								ptr_q[jsel_in] <= ptr_q[jsel_in] + 1'b1;
							end
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (rd_cnt_q == PTR_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					exceeds_q <= ({1'b0, mag_q} > limit);
					state_q   <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid                <= 1'b1;
						out_word.joint_exceeds   <= exceeds_q;
						out_word.collision_joint <= done_q ? step_coll_nx : 4'd0;
						out_word.step_done       <= done_q;
						step_coll_q              <= done_q ? 4'd0 : step_coll_nx;
						state_q                  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/wmrcd_chk.sv
module wmrcd_chk import wmrcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_word
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// One word in flight: input side closes after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accept");

	// Collision report only on the word that ends a step
	a_report_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.step_done |-> out_word.collision_joint == 4'd0)
		else $error("collision report outside step end");

	// Reported joint stays within the joint count
	a_report_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(out_word.collision_joint) <= NUM_JOINTS)
		else $error("collision joint out of range");

endmodule

bind window_max_residual_collision_detect wmrcd_chk u_wmrcd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wmrcd_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_t              in_word   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_word;
	logic             cfg_we    = 1'b0;
	logic [MAG_W-1:0] cfg_wdata = '0;

	// Words waiting to be driven and verdicts waiting to be seen
	in_t  residual_q[$];
	out_t verdict_q[$];
	int   mismatch_count = 0;

	// Handshake flags from the last rising edge, read by the falling-edge drivers
	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;

	// Idle pacing per side
	int send_gap   = 0;
	int recv_gap   = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	// Shadow state of the detector
	logic [MAG_W-1:0] win_mag [NUM_JOINTS][WINDOW_DEPTH];
	logic [MAG_W-1:0] prev_mag [NUM_JOINTS];
	int unsigned      ring_pos [NUM_JOINTS];
	logic [3:0]       step_hi  = '0;
	logic [MAG_W-1:0] margin_q = '0;

	window_max_residual_collision_detect uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Window push, max scan and margin compare for one word
	function automatic out_t detect_collision(input in_t w);
		logic [31:0]      raw;
		logic [31:0]      absval;
		logic [MAG_W-1:0] mag;
		logic [MAG_W-1:0] peak;
		logic [MAG_W+1:0] limit;
		int unsigned      j;
		out_t             r;
		r = '0;
		raw = w.residual;
		absval = raw[31] ? (~raw + 32'd1) : raw;
		// most negative input saturates
		mag = absval[31] ? {MAG_W{1'b1}} : absval[MAG_W-1:0];
		j = w.joint_index;
		if (j < NUM_JOINTS) begin
			win_mag[j][ring_pos[j]] = prev_mag[j];
			ring_pos[j] = (ring_pos[j] + 1) % WINDOW_DEPTH;
			peak = '0;
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				if (win_mag[j][k] > peak)
					peak = win_mag[j][k];
			end
			// 33-bit sum, never wraps
			limit = {2'b00, peak} + {2'b00, margin_q};
			if ({2'b00, mag} > limit) begin
				r.joint_exceeds = 1'b1;
				if (j + 1 > step_hi)
					step_hi = 4'(j + 1);
			end
			prev_mag[j] = mag;
		end
		if (w.last_joint) begin
			r.collision_joint = step_hi;
			step_hi = '0;
		end
		r.step_done = w.last_joint;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	// Sample handshakes, update the shadow state, check results
	always @(posedge clk) begin
		out_t want;
		in_taken  = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (arst_n && cfg_we)
			margin_q = cfg_wdata;
		if (out_taken) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected result word", out_word, 0);
			end else begin
				want = verdict_q.pop_front();
				if (out_word.joint_exceeds !== want.joint_exceeds)
					report_mismatch("joint_exceeds", out_word.joint_exceeds,
						want.joint_exceeds);
				if (out_word.collision_joint !== want.collision_joint)
					report_mismatch("collision_joint", out_word.collision_joint,
						want.collision_joint);
				if (out_word.step_done !== want.step_done)
					report_mismatch("step_done", out_word.step_done, want.step_done);
			end
		end
		if (in_taken)
			verdict_q.push_back(detect_collision(in_word));
	end

	// Input driver: hold while stalled, otherwise wait out the gap and send
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_valid) begin
				if ($urandom_range(0, 31) == 0)
					send_burst = !send_burst;
				send_gap = draw_wait(send_burst);
			end
			if (send_gap == 0 && residual_q.size() != 0) begin
				in_word  <= residual_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				if (send_gap != 0)
					send_gap--;
				in_valid <= 1'b0;
			end
		end
	end

	// Result side: stall for a drawn number of cycles after each word
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 31) == 0)
				recv_burst = !recv_burst;
			recv_gap = draw_wait(recv_burst);
		end else if (recv_gap != 0) begin
			recv_gap--;
		end
		out_stall <= (recv_gap != 0);
	end

	task automatic push_word(input int j, input logic [31:0] r, input bit last);
		in_t w;
		w.joint_index = 3'(j);
		w.residual    = r;
		w.last_joint  = last;
		residual_q.push_back(w);
	endtask

	// Mostly small residuals, with spikes and the extremes mixed in
	function automatic logic [31:0] pick_residual();
		logic [31:0] v;
		int          sel;
		sel = $urandom_range(0, 15);
		case (sel)
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom();
			3: v = 32'h0;
			4, 5: v = $urandom_range(0, 32'h7FFF_FFFF);
			default: v = $urandom_range(0, 32'h0010_0000);
		endcase
		if (sel >= 4 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// One full step, an irregular step, or a stray word
	task automatic queue_random_block(inout int count);
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			for (int j = 0; j < NUM_JOINTS; j++)
				push_word(j, pick_residual(), j == NUM_JOINTS - 1);
			count += NUM_JOINTS;
		end else if (kind < 9) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				push_word($urandom_range(0, 7), pick_residual(), i == n - 1);
			count += n;
		end else begin
			push_word($urandom_range(0, 7), pick_residual(), $urandom_range(0, 1));
			count += 1;
		end
	endtask

	// Sender pauses until every verdict is back, then the latency tail
	task automatic drain();
		do
			@(posedge clk);
		while (residual_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_margin(input logic [MAG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Stimulus sequence
	initial begin
		logic [MAG_W-1:0] margin_plan[6];
		int               count;
		foreach (prev_mag[j]) begin
			prev_mag[j] = '0;
			ring_pos[j] = 0;
			foreach (win_mag[j][k])
				win_mag[j][k] = '0;
		end
		margin_plan[0] = {MAG_W{1'b1}};
		margin_plan[1] = 31'd1;
		margin_plan[2] = 31'h0001_0000;
		margin_plan[3] = 31'($urandom_range(0, 32'h0008_0000));
		margin_plan[4] = 31'd0;
		margin_plan[5] = 31'($urandom());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero window, saturation, top joint, repeats and gaps
		push_word(0, 32'h0000_0000, 1'b0);
		push_word(0, 32'h8000_0000, 1'b0);
		push_word(1, 32'h7FFF_FFFF, 1'b0);
		push_word(2, 32'hFFFF_FFFF, 1'b0);
		push_word(7, 32'h0001_0000, 1'b1);
		push_word(0, 32'h8000_0000, 1'b1);
		push_word(3, 32'h0000_0000, 1'b1);
		push_word(5, 32'h0000_0005, 1'b0);
		push_word(5, 32'h0000_0006, 1'b0);
		push_word(5, 32'h0000_0006, 1'b1);
		push_word(4, 32'hFFFF_FFF9, 1'b0);
		push_word(6, 32'h4000_0000, 1'b0);
		push_word(2, 32'h0000_0001, 1'b1);
		push_word(1, 32'h8000_0001, 1'b1);
		drain();

		// Random phases, one margin setting each
		foreach (margin_plan[p]) begin
			write_margin(margin_plan[p]);
			count = 0;
			while (count < 250)
				queue_random_block(count);
			drain();
		end

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
